// ===== design/swcm_pkg.sv =====
// ----------------------------------------------------------------------------
// swcm_pkg
// Shared types and constants for the sliding window class metrics block.
// ----------------------------------------------------------------------------
package swcm_pkg;

  localparam int WINDOW_MAX  = 1024;
  localparam int NUM_CLASSES = 16;
  localparam int PosW  = $clog2(WINDOW_MAX);
  localparam int CntW  = PosW + 1;
  localparam int ClsW  = $clog2(NUM_CLASSES);
  localparam int ObsW  = ClsW + 1;
  localparam int LblW  = 5;
  localparam int QW    = 17;
  localparam int SumW  = QW + CntW;
  localparam logic [CntW-1:0] WinReset = CntW'(256);

  localparam logic CmdObserve = 1'b0;
  localparam logic CmdClear   = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StEvict,
    StAdd,
    StAccDiv,
    StClsLoad,
    StClsDiv,
    StMeanDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic clear;
    logic latch;
    logic ring_read;
    logic evict;
    logic add;
    logic acc_start;
    logic cls_load;
    logic cls_start;
    logic cls_next;
    logic mean_start;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic record;
    logic do_evict;
    logic cmd_clear;
    logic div_busy;
    logic cls_obs;
    logic cls_last;
  } stat_t;

endpackage

// ===== design/swcm_if.sv =====
// ----------------------------------------------------------------------------
// swcm_if
// Valid/ready channel interfaces for input words, result words and config.
// ----------------------------------------------------------------------------
interface swcm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [swcm_pkg::LblW-1:0] predicted_label;
  logic signed [swcm_pkg::LblW-1:0] true_label;
  modport source (output valid, cmd, predicted_label, true_label, input ready);
  modport sink   (input valid, cmd, predicted_label, true_label, output ready);
endinterface

interface swcm_out_if;
  logic                         valid;
  logic                         ready;
  logic [swcm_pkg::CntW-1:0]    window_fill;
  logic [swcm_pkg::CntW-1:0]    correct_in_window;
  logic [swcm_pkg::QW-1:0]      accuracy_q16;
  logic [swcm_pkg::QW-1:0]      avg_f1_q16;
  logic [swcm_pkg::ObsW-1:0]    classes_observed;
  logic                         label_rejected;
  modport source (output valid, window_fill, correct_in_window, accuracy_q16,
                  avg_f1_q16, classes_observed, label_rejected, input ready);
  modport sink   (input valid, window_fill, correct_in_window, accuracy_q16,
                  avg_f1_q16, classes_observed, label_rejected, output ready);
endinterface

interface swcm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [swcm_pkg::CntW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/swcm_div.sv =====
// ----------------------------------------------------------------------------
// swcm_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swcm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [swcm_pkg::SumW-1:0]    num_i,
  input  logic [swcm_pkg::SumW-1:0]    den_i,
  output logic                         busy_o,
  output logic [swcm_pkg::SumW-1:0]    quo_o
);
  localparam int W  = swcm_pkg::SumW;
  localparam int IW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d, den_q, den_d;
  logic [W:0]    rem_q, rem_d, trial;
  logic [IW-1:0] cnt_q, cnt_d;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q[W-1:0], quo_q[W-1]};
    if (start_i) begin
      quo_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = IW'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

// ===== design/swcm_datapath.sv =====
// ----------------------------------------------------------------------------
// swcm_datapath
// Ring memories, class counters, divider and result register.
// ----------------------------------------------------------------------------
module swcm_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  swcm_pkg::ctrl_t            ctrl_i,
  output swcm_pkg::stat_t            stat_o,
  input  logic                       in_cmd_i,
  input  logic [swcm_pkg::LblW-1:0]  in_pred_i,
  input  logic [swcm_pkg::LblW-1:0]  in_true_i,
  input  logic [swcm_pkg::CntW-1:0]  win_i,
  output logic [swcm_pkg::CntW-1:0]  fill_o,
  output logic [swcm_pkg::CntW-1:0]  correct_o,
  output logic [swcm_pkg::QW-1:0]    acc_o,
  output logic [swcm_pkg::QW-1:0]    f1_o,
  output logic [swcm_pkg::ObsW-1:0]  obs_o,
  output logic                       rej_o
);
  localparam int PosW = swcm_pkg::PosW;
  localparam int CntW = swcm_pkg::CntW;
  localparam int ClsW = swcm_pkg::ClsW;
  localparam int LblW = swcm_pkg::LblW;
  localparam int SumW = swcm_pkg::SumW;
  localparam int NC   = swcm_pkg::NUM_CLASSES;

  logic [LblW-1:0] pred_ring [swcm_pkg::WINDOW_MAX];
  logic [LblW-1:0] true_ring [swcm_pkg::WINDOW_MAX];
  logic [LblW-1:0] rd_pred_q, rd_true_q, pred_q, true_q;
  logic            cmd_q, rej_q;
  logic [CntW-1:0] tp_q [NC];
  logic [CntW-1:0] fp_q [NC];
  logic [CntW-1:0] fn_q [NC];
  logic [CntW-1:0] correct_q, fill_q, ws;
  logic [PosW-1:0] wpos_q;
  logic [ClsW-1:0] cls_q;
  logic [SumW-1:0] sum_q, num, den, quo;
  logic [swcm_pkg::ObsW-1:0] obs_q;
  logic            div_start, busy, record;
  logic [SumW-1:0] acc_q;
  logic [CntW:0]   tp2;
  logic [CntW+1:0] tot;

  function automatic logic lbl_ok(logic [LblW-1:0] l);
    return (l == '1) || !l[LblW-1];
  endfunction

  assign ws = (win_i > CntW'(swcm_pkg::WINDOW_MAX)) ? CntW'(swcm_pkg::WINDOW_MAX) : win_i;
  assign record = (cmd_q == swcm_pkg::CmdObserve) && lbl_ok(pred_q) && lbl_ok(true_q)
                  && (ws != '0) && ({1'b0, wpos_q} < ws);

  assign tp2 = {tp_q[cls_q], 1'b0};
  assign tot = {1'b0, tp2} + {2'b0, fp_q[cls_q]} + {2'b0, fn_q[cls_q]};

  always_comb begin
    num = '0;
    den = SumW'(1);
    if (ctrl_i.acc_start) begin
      num = SumW'({correct_q, 16'b0});
      den = SumW'(fill_q);
    end else if (ctrl_i.cls_start) begin
      num = SumW'({tp2, 16'b0});
      den = SumW'(tot);
    end else if (ctrl_i.mean_start) begin
      num = sum_q;
      den = SumW'(obs_q);
    end
  end
  assign div_start = ctrl_i.acc_start | ctrl_i.cls_start | ctrl_i.mean_start;

  swcm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .busy_o(busy), .quo_o(quo)
  );

  assign stat_o.record    = record;
  assign stat_o.do_evict  = fill_q >= ws;
  assign stat_o.cmd_clear = (cmd_q == swcm_pkg::CmdClear);
  assign stat_o.div_busy  = busy;
  assign stat_o.cls_obs   = (tot != '0);
  assign stat_o.cls_last  = (cls_q == ClsW'(NC - 1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q  <= in_cmd_i;
      pred_q <= in_pred_i;
      true_q <= in_true_i;
    end
    if (ctrl_i.ring_read) begin
      rd_pred_q <= pred_ring[wpos_q];
      rd_true_q <= true_ring[wpos_q];
    end
    if (ctrl_i.add) begin
      pred_ring[wpos_q] <= pred_q;
      true_ring[wpos_q] <= true_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NC; i++) begin
        tp_q[i] <= '0;
        fp_q[i] <= '0;
        fn_q[i] <= '0;
      end
      correct_q <= '0;
      fill_q    <= '0;
      wpos_q    <= '0;
      cls_q     <= '0;
      sum_q     <= '0;
      obs_q     <= '0;
      acc_q     <= '0;
      rej_q     <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        for (int i = 0; i < NC; i++) begin
          tp_q[i] <= '0;
          fp_q[i] <= '0;
          fn_q[i] <= '0;
        end
        correct_q <= '0;
        fill_q    <= '0;
        wpos_q    <= '0;
      end
      if (ctrl_i.latch) begin
        rej_q <= (in_cmd_i == swcm_pkg::CmdObserve) &&
                 !(lbl_ok(in_pred_i) && lbl_ok(in_true_i));
      end
      if (ctrl_i.evict) begin
        if (rd_pred_q == rd_true_q) begin
          if (!rd_true_q[LblW-1]) tp_q[rd_true_q[ClsW-1:0]] <= tp_q[rd_true_q[ClsW-1:0]] - 1'b1;
          correct_q <= correct_q - 1'b1;
        end else begin
          if (!rd_pred_q[LblW-1]) fp_q[rd_pred_q[ClsW-1:0]] <= fp_q[rd_pred_q[ClsW-1:0]] - 1'b1;
          if (!rd_true_q[LblW-1]) fn_q[rd_true_q[ClsW-1:0]] <= fn_q[rd_true_q[ClsW-1:0]] - 1'b1;
        end
      end
      if (ctrl_i.add) begin
        if (pred_q == true_q) begin
          if (!true_q[LblW-1]) tp_q[true_q[ClsW-1:0]] <= tp_q[true_q[ClsW-1:0]] + 1'b1;
          correct_q <= correct_q + 1'b1;
        end else begin
          if (!pred_q[LblW-1]) fp_q[pred_q[ClsW-1:0]] <= fp_q[pred_q[ClsW-1:0]] + 1'b1;
          if (!true_q[LblW-1]) fn_q[true_q[ClsW-1:0]] <= fn_q[true_q[ClsW-1:0]] + 1'b1;
        end
        if (fill_q < ws) fill_q <= fill_q + 1'b1;
        wpos_q <= ({1'b0, wpos_q} + 1'b1 >= ws) ? '0 : wpos_q + 1'b1;
      end
      if (ctrl_i.acc_start) begin
        sum_q <= '0;
        obs_q <= '0;
        cls_q <= '0;
      end
      if (ctrl_i.cls_load) begin
        if (fill_q == '0) acc_q <= '0;
        else              acc_q <= quo;
      end
      if (ctrl_i.cls_start) obs_q <= obs_q + 1'b1;
      if (ctrl_i.cls_next) begin
        if (stat_o.cls_obs) sum_q <= sum_q + quo;
        cls_q <= cls_q + 1'b1;
      end
    end
  end

  logic [CntW-1:0]           fill_r, corr_r;
  logic [swcm_pkg::QW-1:0]   acc_r, f1_r;
  logic [swcm_pkg::ObsW-1:0] obs_r;
  logic                      rej_r;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      fill_r <= fill_q;
      corr_r <= correct_q;
      acc_r  <= acc_q[swcm_pkg::QW-1:0];
      f1_r   <= (obs_q == '0) ? '0 : quo[swcm_pkg::QW-1:0];
      obs_r  <= obs_q;
      rej_r  <= rej_q;
    end
  end
  assign fill_o    = fill_r;
  assign correct_o = corr_r;
  assign acc_o     = acc_r;
  assign f1_o      = f1_r;
  assign obs_o     = obs_r;
  assign rej_o     = rej_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(swcm_pkg::WINDOW_MAX)) else $error("fill beyond max");
  a_correct_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    correct_q <= fill_q) else $error("correct exceeds fill");
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (fill_q == '0 && wpos_q == '0)) else $error("clear failed");
`endif
endmodule

// ===== design/swcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swcm_ctrl
// Sequencer: update, accuracy divide, per-class F1 divides, mean divide.
// ----------------------------------------------------------------------------
module swcm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            cfg_fire_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  swcm_pkg::stat_t stat_i,
  output swcm_pkg::ctrl_t ctrl_o
);
  swcm_pkg::state_e state_q, state_d;
  logic             ovalid_q, ovalid_d;
  logic [1:0]       sub_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swcm_pkg::StIdle:    if (in_valid_i) state_d = swcm_pkg::StRead;
      swcm_pkg::StRead: begin
        if (stat_i.cmd_clear || !stat_i.record) state_d = swcm_pkg::StAccDiv;
        else if (stat_i.do_evict)               state_d = swcm_pkg::StEvict;
        else                                    state_d = swcm_pkg::StAdd;
      end
      swcm_pkg::StEvict:   state_d = swcm_pkg::StAdd;
      swcm_pkg::StAdd:     state_d = swcm_pkg::StAccDiv;
      swcm_pkg::StAccDiv:  if (!stat_i.div_busy && (sub_q != 2'd0))
                             state_d = swcm_pkg::StClsLoad;
      swcm_pkg::StClsLoad: begin
        if (stat_i.cls_obs)       state_d = swcm_pkg::StClsDiv;
        else if (stat_i.cls_last) state_d = swcm_pkg::StMeanDiv;
      end
      swcm_pkg::StClsDiv: begin
        if (!stat_i.div_busy && !ctrl_o.cls_start) begin
          state_d = stat_i.cls_last ? swcm_pkg::StMeanDiv : swcm_pkg::StClsLoad;
        end
      end
      swcm_pkg::StMeanDiv: if (!stat_i.div_busy && !ctrl_o.mean_start && !ovalid_q)
                             state_d = swcm_pkg::StOut;
      swcm_pkg::StOut:     state_d = swcm_pkg::StIdle;
      default:             state_d = swcm_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.latch      = (state_q == swcm_pkg::StIdle) && in_valid_i;
    ctrl_o.clear      = cfg_fire_i ||
                        ((state_q == swcm_pkg::StRead) && stat_i.cmd_clear);
    ctrl_o.ring_read  = (state_q == swcm_pkg::StRead);
    ctrl_o.evict      = (state_q == swcm_pkg::StEvict);
    ctrl_o.add        = (state_q == swcm_pkg::StAdd);
    ctrl_o.acc_start  = (state_q == swcm_pkg::StAccDiv) && (sub_q == 2'd0);
    ctrl_o.cls_load   = (state_q == swcm_pkg::StAccDiv) && !stat_i.div_busy && (sub_q != 2'd0);
    ctrl_o.cls_start  = (state_q == swcm_pkg::StClsLoad) && stat_i.cls_obs;
    ctrl_o.cls_next   = ((state_q == swcm_pkg::StClsLoad) && !stat_i.cls_obs && !stat_i.cls_last)
                      || ((state_q == swcm_pkg::StClsDiv) && !stat_i.div_busy
                          && !(sub_q == 2'd0));
    ctrl_o.mean_start = ((state_q == swcm_pkg::StMeanDiv) && (sub_q == 2'd0));
    ctrl_o.out_load   = (state_q == swcm_pkg::StOut);
  end

  // sub_q marks the first cycle of a divide-wait state (divider not yet started)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sub_q <= 2'd0;
    else if (state_d != state_q) sub_q <= 2'd0;
    else sub_q <= 2'd1;
  end

  assign ovalid_d = ctrl_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swcm_pkg::StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == swcm_pkg::StIdle);
  assign out_valid_o = ovalid_q;

`ifndef SYNTH
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.evict && ctrl_o.add)) else $error("evict and add together");
  a_load_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> out_valid_o) else $error("result lost");
  a_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.latch |-> state_q == swcm_pkg::StIdle) else $error("latch outside idle");
`endif
endmodule

// ===== design/sliding_window_class_metrics.sv =====
// Per accepted word: read, evict and add as needed; then the accuracy, each
// observed class and the mean each hold the shared 28-bit serial divider in
// turn, and an unobserved class is passed over without a divide. One word at a
// time: a new word is taken only after the last result word has been loaded.
// Reset: counters, fill and write position clear at once; window length = 256;
// ring contents stay undefined until written.
// ----------------------------------------------------------------------------
// sliding_window_class_metrics
// Windowed accuracy and macro F1 over a ring of recent label pairs.
// ----------------------------------------------------------------------------
module sliding_window_class_metrics (
  input  logic             clk_i,
  input  logic             rst_ni,
  swcm_in_if.sink          in_if,
  swcm_out_if.source       out_if,
  swcm_cfg_if.sink         cfg_if
);
  swcm_pkg::ctrl_t ctrl;
  swcm_pkg::stat_t stat;
  logic [swcm_pkg::CntW-1:0] win_q;
  logic cfg_fire, in_rdy;

  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) win_q <= swcm_pkg::WinReset;
    else if (cfg_fire) win_q <= cfg_if.data;
  end

  assign in_if.ready = in_rdy;

  swcm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_rdy),
    .cfg_fire_i(cfg_fire),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  swcm_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .in_cmd_i(in_if.cmd), .in_pred_i(in_if.predicted_label),
    .in_true_i(in_if.true_label), .win_i(win_q),
    .fill_o(out_if.window_fill), .correct_o(out_if.correct_in_window),
    .acc_o(out_if.accuracy_q16), .f1_o(out_if.avg_f1_q16),
    .obs_o(out_if.classes_observed), .rej_o(out_if.label_rejected)
  );
endmodule

// ===== bench/tb_swcm_if.sv =====
// ----------------------------------------------------------------------------
// tb_swcm_if
// Bench-side notes: the channel interfaces come from the design folder; this
// file holds the small bench package with the result word type used by the bench.
// ----------------------------------------------------------------------------
package tb_swcm_pkg;

  typedef struct packed {
    logic [swcm_pkg::CntW-1:0] fill;
    logic [swcm_pkg::CntW-1:0] correct;
    logic [swcm_pkg::QW-1:0]   acc;
    logic [swcm_pkg::QW-1:0]   f1;
    logic [swcm_pkg::ObsW-1:0] observed;
    logic                      rejected;
  } metrics_t;
endpackage

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks sliding_window_class_metrics: a built-in window and class-count
// tracker predicts every result word, which is compared field by field.
// Directed and random label streams run over several window sizes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  swcm_in_if  in_if ();
  swcm_out_if out_if ();
  swcm_cfg_if cfg_if ();

  sliding_window_class_metrics uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // tracker state
  int win_size;
  int pred_hist [swcm_pkg::WINDOW_MAX];
  int true_hist [swcm_pkg::WINDOW_MAX];
  int tp_cnt [swcm_pkg::NUM_CLASSES];
  int fp_cnt [swcm_pkg::NUM_CLASSES];
  int fn_cnt [swcm_pkg::NUM_CLASSES];
  int correct_cnt, fill_cnt, wr_pos;

  tb_swcm_pkg::metrics_t expected_words [$];
  int errors = 0;
  int words_seen = 0;
  int rejects_seen = 0;
  bit quiet_sink = 1'b0;

  function automatic void clear_tracker();
    for (int c = 0; c < swcm_pkg::NUM_CLASSES; c++) begin
      tp_cnt[c] = 0; fp_cnt[c] = 0; fn_cnt[c] = 0;
    end
    correct_cnt = 0; fill_cnt = 0; wr_pos = 0;
  endfunction

  function automatic void tally_pair(int p, int t, int d);
    if (p == t) begin
      if (t >= 0) tp_cnt[t] += d;
      correct_cnt += d;
    end else begin
      if (p >= 0) fp_cnt[p] += d;
      if (t >= 0) fn_cnt[t] += d;
    end
  endfunction

  function automatic tb_swcm_pkg::metrics_t predict_metrics(logic cmd, logic [4:0] pl,
                                                            logic [4:0] tl);
    tb_swcm_pkg::metrics_t m;
    int p, t, ws, obs;
    bit rej;
    longint sum;
    p = $signed(pl); t = $signed(tl);
    ws = win_size > swcm_pkg::WINDOW_MAX ? swcm_pkg::WINDOW_MAX : win_size;
    rej = 1'b0;
    if (cmd == swcm_pkg::CmdClear) clear_tracker();
    else if (p < -1 || p >= swcm_pkg::NUM_CLASSES || t < -1 || t >= swcm_pkg::NUM_CLASSES)
      rej = 1'b1;
    else if (ws != 0 && wr_pos < ws) begin
      if (fill_cnt >= ws) tally_pair(pred_hist[wr_pos], true_hist[wr_pos], -1);
      else fill_cnt++;
      pred_hist[wr_pos] = p; true_hist[wr_pos] = t;
      tally_pair(p, t, 1);
      wr_pos = (wr_pos + 1 >= ws) ? 0 : wr_pos + 1;
    end
    sum = 0; obs = 0;
    for (int c = 0; c < swcm_pkg::NUM_CLASSES; c++) begin
      if (tp_cnt[c] + fp_cnt[c] + fn_cnt[c] != 0) begin
        obs++;
        sum += (longint'(2 * tp_cnt[c]) << 16) / (2 * tp_cnt[c] + fp_cnt[c] + fn_cnt[c]);
      end
    end
    m.fill = swcm_pkg::CntW'(fill_cnt);
    m.correct = swcm_pkg::CntW'(correct_cnt);
    m.acc = fill_cnt ? swcm_pkg::QW'((longint'(correct_cnt) << 16) / fill_cnt) : '0;
    m.f1 = obs ? swcm_pkg::QW'(sum / obs) : '0;
    m.observed = swcm_pkg::ObsW'(obs);
    m.rejected = rej;
    return m;
  endfunction

  // sender idle control
  bit no_idle = 1'b0;

  task automatic send_word(logic cmd, logic [4:0] pl, logic [4:0] tl);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 6) @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.predicted_label <= pl;
    in_if.true_label <= tl;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_words.push_back(predict_metrics(cmd, pl, tl));
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
  endtask

  task automatic write_window(int ws);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= swcm_pkg::CntW'(ws);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    win_size = ws;
    clear_tracker();
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [4:0] rand_label();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 5'h1f;
    if (r < 11) return 5'($urandom_range(16, 30));
    return 5'($urandom_range(0, 15));
  endfunction

  task automatic random_burst(int n, int classes);
    int p, t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0)
        send_word(swcm_pkg::CmdClear, 5'($urandom), 5'($urandom));
      else if ($urandom_range(99) < 3)
        send_word(swcm_pkg::CmdObserve, rand_label(), rand_label());
      else begin
        t = $urandom_range(0, classes);
        t = (t == classes) ? -1 : t;
        p = ($urandom_range(99) < 55) ? t : $urandom_range(0, classes) - 1;
        send_word(swcm_pkg::CmdObserve, 5'(p), 5'(t));
      end
    end
  endtask

  task automatic test_directed();
    send_word(swcm_pkg::CmdObserve, 5'd0, 5'd0);
    send_word(swcm_pkg::CmdObserve, 5'd15, 5'd15);
    send_word(swcm_pkg::CmdObserve, 5'h1f, 5'h1f);
    send_word(swcm_pkg::CmdObserve, 5'd3, 5'h1f);
    send_word(swcm_pkg::CmdObserve, 5'h1f, 5'd7);
    send_word(swcm_pkg::CmdObserve, 5'd15, 5'd0);
    send_word(swcm_pkg::CmdObserve, 5'd16, 5'd2);
    send_word(swcm_pkg::CmdObserve, 5'd2, 5'h10);
    send_word(swcm_pkg::CmdObserve, 5'h1e, 5'h1e);
    send_word(swcm_pkg::CmdClear, 5'h0a, 5'h15);
    send_word(swcm_pkg::CmdObserve, 5'd1, 5'd1);
  endtask

  task automatic test_window_wrap();
    write_window(3);
    for (int i = 0; i < 10; i++)
      send_word(swcm_pkg::CmdObserve, 5'(i % 4), 5'((i * 3) % 5));
    write_window(1);
    random_burst(12, 4);
  endtask

  task automatic test_disabled();
    write_window(0);
    send_word(swcm_pkg::CmdObserve, 5'd4, 5'd4);
    send_word(swcm_pkg::CmdObserve, 5'h11, 5'd4);
    send_word(swcm_pkg::CmdClear, 5'd0, 5'd0);
  endtask

  task automatic test_random_sizes();
    int sizes [6] = '{5, 17, 64, 1024, 2047, 256};
    foreach (sizes[k]) begin
      write_window(sizes[k]);
      no_idle = (k == 2);
      quiet_sink = (k == 2);
      random_burst(k >= 3 ? 330 : 180, (k % 2) ? 16 : 5);
      if (k == 1) drain();
    end
    no_idle = 1'b0;
    quiet_sink = 1'b0;
  endtask

  always @(posedge clk_i) begin
    tb_swcm_pkg::metrics_t got, exp_m;
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.window_fill, out_if.correct_in_window, out_if.accuracy_q16,
              out_if.avg_f1_q16, out_if.classes_observed, out_if.label_rejected};
      words_seen++;
      if (got.rejected) rejects_seen++;
      if (expected_words.size() == 0) begin
        $display("%t unexpected result word %p", $time, got);
        errors++;
      end else begin
        exp_m = expected_words.pop_front();
        if (got.fill !== exp_m.fill) begin
          $display("%t window_fill exp %0d got %0d", $time, exp_m.fill, got.fill); errors++;
        end
        if (got.correct !== exp_m.correct) begin
          $display("%t correct exp %0d got %0d", $time, exp_m.correct, got.correct); errors++;
        end
        if (got.acc !== exp_m.acc) begin
          $display("%t accuracy exp %0d got %0d", $time, exp_m.acc, got.acc); errors++;
        end
        if (got.f1 !== exp_m.f1) begin
          $display("%t avg_f1 exp %0d got %0d", $time, exp_m.f1, got.f1); errors++;
        end
        if (got.observed !== exp_m.observed) begin
          $display("%t classes exp %0d got %0d", $time, exp_m.observed, got.observed);
          errors++;
        end
        if (got.rejected !== exp_m.rejected) begin
          $display("%t rejected exp %0d got %0d", $time, exp_m.rejected, got.rejected);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= quiet_sink || ($urandom_range(99) >= 6);
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = swcm_pkg::CmdObserve;
    in_if.predicted_label = '0;
    in_if.true_label = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    win_size = swcm_pkg::WinReset;
    clear_tracker();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_window_wrap();
    test_disabled();
    test_random_sizes();
    drain();
    $display("covered %0d result words, %0d rejected labels, window sizes 0..2047",
             words_seen, rejects_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("** sliding_window_class_metrics: PASSED **");
    end else begin
      $display("** sliding_window_class_metrics: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** sliding_window_class_metrics: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
design/swcm_pkg.sv
design/swcm_if.sv
design/swcm_div.sv
design/swcm_datapath.sv
design/swcm_ctrl.sv
design/sliding_window_class_metrics.sv
bench/tb_swcm_if.sv
bench/tb.sv
